// ===== rtl/weighted_sum_newton_divide_unit_macros.svh =====
// assertion helpers used by the top-level rtl
`ifndef WEIGHTED_SUM_NEWTON_DIVIDE_UNIT_MACROS_SVH
`define WEIGHTED_SUM_NEWTON_DIVIDE_UNIT_MACROS_SVH

`ifndef SYNTH
`define WSND_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WSND_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WSND_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WSND_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/wsnd_pkg.sv =====
package wsnd_pkg;

    localparam int NEWTON_ROUNDS    = 3;
    localparam int SEED_TABLE_DEPTH = 128;

    localparam logic [31:0] QNAN     = 32'h7fc00000;
    localparam logic [31:0] BAD_WORD = 32'hffffffff;
    localparam logic [31:0] TWO_F    = 32'h40000000;

    typedef struct packed {
        logic        valid;
        logic        bad;
        logic [31:0] q;
        logic [31:0] t;
    } t_item;

    localparam logic [22:0] SEED_MANT [SEED_TABLE_DEPTH] = '{
        23'h7f8000, 23'h7e0000, 23'h7c0000, 23'h7a0000,
        23'h780000, 23'h760000, 23'h740000, 23'h720000,
        23'h700000, 23'h6f0000, 23'h6d0000, 23'h6b0000,
        23'h6a0000, 23'h680000, 23'h660000, 23'h650000,
        23'h630000, 23'h610000, 23'h600000, 23'h5e0000,
        23'h5d0000, 23'h5b0000, 23'h5a0000, 23'h590000,
        23'h570000, 23'h560000, 23'h540000, 23'h530000,
        23'h520000, 23'h500000, 23'h4f0000, 23'h4e0000,
        23'h4c0000, 23'h4b0000, 23'h4a0000, 23'h490000,
        23'h470000, 23'h460000, 23'h450000, 23'h440000,
        23'h430000, 23'h410000, 23'h400000, 23'h3f0000,
        23'h3e0000, 23'h3d0000, 23'h3c0000, 23'h3b0000,
        23'h3a0000, 23'h390000, 23'h380000, 23'h370000,
        23'h360000, 23'h350000, 23'h340000, 23'h330000,
        23'h320000, 23'h310000, 23'h300000, 23'h2f0000,
        23'h2e0000, 23'h2d0000, 23'h2c0000, 23'h2b0000,
        23'h2a0000, 23'h290000, 23'h280000, 23'h280000,
        23'h270000, 23'h260000, 23'h250000, 23'h240000,
        23'h230000, 23'h230000, 23'h220000, 23'h210000,
        23'h200000, 23'h1f0000, 23'h1f0000, 23'h1e0000,
        23'h1d0000, 23'h1c0000, 23'h1c0000, 23'h1b0000,
        23'h1a0000, 23'h190000, 23'h190000, 23'h180000,
        23'h170000, 23'h170000, 23'h160000, 23'h150000,
        23'h140000, 23'h140000, 23'h130000, 23'h120000,
        23'h120000, 23'h110000, 23'h100000, 23'h100000,
        23'h0f0000, 23'h0f0000, 23'h0e0000, 23'h0d0000,
        23'h0d0000, 23'h0c0000, 23'h0c0000, 23'h0b0000,
        23'h0a0000, 23'h0a0000, 23'h090000, 23'h090000,
        23'h080000, 23'h070000, 23'h070000, 23'h060000,
        23'h060000, 23'h050000, 23'h050000, 23'h040000,
        23'h040000, 23'h030000, 23'h030000, 23'h020000,
        23'h020000, 23'h010000, 23'h010000, 23'h000000
    };

    function automatic logic [5:0] lzc50(input logic [49:0] v);
        logic [5:0] n;
        n = 6'd50;
        for (int i = 0; i < 50; i++) begin
            if (v[i]) begin
                n = 6'(49 - i);
            end
        end
        return n;
    endfunction

    // m has its leading one at bit 49, be is the biased exponent of that bit
    function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] be,
                                               input logic [49:0] m);
        logic [5:0]  sh;
        logic [49:0] mm;
        logic        stk;
        logic        rup;
        logic [24:0] sum;
        logic [8:0]  fld;
        logic [22:0] man;
        sh = 6'd0;
        if (be < 12'sd1) begin
            if (be < -12'sd48) begin
                sh = 6'd50;
            end else begin
                sh = 6'(12'sd1 - be);
            end
        end
        mm  = m >> sh;
        stk = |(m & ~({50{1'b1}} << sh));
        rup = mm[25] & (stk | (|mm[24:0]) | mm[26]);
        sum = {1'b0, mm[49:26]} + 25'(rup);
        if (be >= 12'sd1) begin
            fld = be[8:0] + 9'(sum[24]);
            man = sum[24] ? sum[23:1] : sum[22:0];
        end else begin
            fld = {8'd0, sum[23]};
            man = sum[22:0];
        end
        if (fld >= 9'd255) begin
            return {s, 8'hff, 23'd0};
        end
        return {s, fld[7:0], man};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic        za, zb, ia, ib, na, nb;
        logic [7:0]  xa, xb;
        logic [47:0] prod;
        logic [49:0] w;
        logic [5:0]  lz;
        logic signed [11:0] be;
        s  = a[31] ^ b[31];
        za = (a[30:0] == 31'd0);
        zb = (b[30:0] == 31'd0);
        ia = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
        ib = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
        na = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        nb = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        xa = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        xb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        if (na || nb || (ia && zb) || (ib && za)) begin
            return QNAN;
        end
        if (ia || ib) begin
            return {s, 8'hff, 23'd0};
        end
        if (za || zb) begin
            return {s, 31'd0};
        end
        prod = {24'd0, (a[30:23] != 8'd0), a[22:0]} * {24'd0, (b[30:23] != 8'd0), b[22:0]};
        w    = {prod, 2'b00};
        lz   = lzc50(w);
        w    = w << lz;
        be   = $signed({4'd0, xa}) + $signed({4'd0, xb}) - 12'sd126 - $signed({6'd0, lz});
        return round_pack(s, be, w);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        ia, ib, na, nb;
        logic [31:0] x, y;
        logic [7:0]  xe, ye, d;
        logic [49:0] mx, my, ms, r;
        logic        stk;
        logic [5:0]  lz;
        logic signed [11:0] be;
        ia = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
        ib = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
        na = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        nb = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        if (na || nb || (ia && ib && (a[31] != b[31]))) begin
            return QNAN;
        end
        if (ia) begin
            return a;
        end
        if (ib) begin
            return b;
        end
        if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        xe = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ye = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d  = xe - ye;
        mx = {1'b0, (x[30:23] != 8'd0), x[22:0], 25'd0};
        my = {1'b0, (y[30:23] != 8'd0), y[22:0], 25'd0};
        if (d >= 8'd50) begin
            ms  = 50'd0;
            stk = |my;
        end else begin
            ms  = my >> d;
            stk = |(my & ~({50{1'b1}} << d));
        end
        ms[0] = ms[0] | stk;
        r = (x[31] == y[31]) ? (mx + ms) : (mx - ms);
        if (r == 50'd0) begin
            return {a[31] & b[31], 31'd0};
        end
        lz = lzc50(r);
        r  = r << lz;
        be = $signed({4'd0, xe}) + 12'sd1 - $signed({6'd0, lz});
        return round_pack(x[31], be, r);
    endfunction

    function automatic logic [31:0] seed_of(input logic [31:0] w);
        logic [7:0] e;
        e = w[30:23];
        if (e == 8'd0 || e > 8'd252) begin
            return {w[31], 31'd0};
        end
        return {w[31], 8'(9'd253 - {1'b0, e}), SEED_MANT[w[22:16]]};
    endfunction

endpackage

// ===== rtl/weighted_sum_newton_divide_unit.sv =====
// path: front multiply/add/seed stages, a newton cell for each round, then the output register
// throughput: one request per cycle unless a result waits for i_ready, set by the fully pipelined multiply/add stages
// the whole pipeline holds while a finished result waits for i_ready
// reset: synchronous active-low i_rst_n clears all valid bits; data is not reset
`include "weighted_sum_newton_divide_unit_macros.svh"
module weighted_sum_newton_divide_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_first_operand,
    input  logic [31:0] i_first_weight,
    input  logic [31:0] i_second_operand,
    input  logic [31:0] i_second_weight,
    input  logic [31:0] i_offset_term,
    input  logic [31:0] i_divisor,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_quotient
);
    import wsnd_pkg::*;

    logic        en;
    t_item       chain [NEWTON_ROUNDS+1];
    logic        r_valid;
    logic        r_bad;
    logic [31:0] r_quotient;

    assign en = ~r_valid | i_ready;

    wsnd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_a     (i_first_operand),
        .i_b     (i_first_weight),
        .i_c     (i_second_operand),
        .i_d     (i_second_weight),
        .i_e     (i_offset_term),
        .i_f     (i_divisor),
        .o_item  (chain[0])
    );

    for (genvar g = 0; g < NEWTON_ROUNDS; g++) begin : g_round
        wsnd_newton_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_item  (chain[g]),
            .o_item  (chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= chain[NEWTON_ROUNDS].valid;
        end
    end

    // any nan, and any bad divisor, leaves as the all-ones pattern
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bad <= chain[NEWTON_ROUNDS].bad;
            if (chain[NEWTON_ROUNDS].bad || (chain[NEWTON_ROUNDS].q[30:23] == 8'hff &&
                    chain[NEWTON_ROUNDS].q[22:0] != 23'd0)) begin
                r_quotient <= BAD_WORD;
            end else begin
                r_quotient <= chain[NEWTON_ROUNDS].q;
            end
        end
    end

    assign o_ready    = en;
    assign o_valid    = r_valid;
    assign o_quotient = r_quotient;

    `WSND_ASSERT_NOW(a_stall_only_on_output, i_clk, i_rst_n, !o_ready, o_valid && !i_ready)
    `WSND_ASSERT_NOW(a_bad_gives_ones, i_clk, i_rst_n, o_valid && r_bad, o_quotient == BAD_WORD)
    `WSND_ASSERT_NOW(a_nan_canonical, i_clk, i_rst_n, o_valid && o_quotient[30:23] == 8'hff,
        o_quotient == BAD_WORD || o_quotient[22:0] == 23'd0)
endmodule

// ===== rtl/wsnd_front.sv =====
module wsnd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [31:0]        i_a,
    input  logic [31:0]        i_b,
    input  logic [31:0]        i_c,
    input  logic [31:0]        i_d,
    input  logic [31:0]        i_e,
    input  logic [31:0]        i_f,
    output wsnd_pkg::t_item    o_item
);
    import wsnd_pkg::*;

    logic        r1_valid, r2_valid, r3_valid;
    logic        r1_bad, r2_bad, r3_bad;
    logic [31:0] r1_p, r1_s, r1_e, r1_f;
    logic [31:0] r2_n, r2_e, r2_f;
    logic [31:0] r3_n, r3_r, r3_f;
    t_item       r_item;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p       <= fp_mul(i_a, i_b);
            r1_s       <= fp_mul(i_c, i_d);
            r1_e       <= i_e;
            r1_f       <= i_f;
            r1_bad     <= (i_f[30:0] == 31'd0) || (i_f[30:23] == 8'hff);
            r2_n       <= fp_add(r1_p, r1_s);
            r2_e       <= r1_e;
            r2_f       <= r1_f;
            r2_bad     <= r1_bad;
            r3_n       <= fp_add(r2_n, r2_e);
            r3_r       <= seed_of(r2_f);
            r3_f       <= r2_f;
            r3_bad     <= r2_bad;
            r_item.q   <= fp_mul(r3_n, r3_r);
            r_item.t   <= fp_mul(r3_r, r3_f);
            r_item.bad <= r3_bad;
        end
        if (!i_rst_n) begin
            r1_valid     <= 1'b0;
            r2_valid     <= 1'b0;
            r3_valid     <= 1'b0;
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r1_valid     <= i_valid;
            r2_valid     <= r1_valid;
            r3_valid     <= r2_valid;
            r_item.valid <= r3_valid;
        end
    end

    assign o_item = r_item;
endmodule

// ===== rtl/wsnd_newton_cell.sv =====
module wsnd_newton_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  wsnd_pkg::t_item    i_item,
    output wsnd_pkg::t_item    o_item
);
    import wsnd_pkg::*;

    t_item       r_mid;
    logic [31:0] r_k;
    t_item       r_item;

    // k = 2 - t, then q *= k and t *= k
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k        <= fp_add(TWO_F, {~i_item.t[31], i_item.t[30:0]});
            r_mid.q    <= i_item.q;
            r_mid.t    <= i_item.t;
            r_mid.bad  <= i_item.bad;
            r_item.q   <= fp_mul(r_mid.q, r_k);
            r_item.t   <= fp_mul(r_k, r_mid.t);
            r_item.bad <= r_mid.bad;
        end
        if (!i_rst_n) begin
            r_mid.valid  <= 1'b0;
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_mid.valid  <= i_item.valid;
            r_item.valid <= r_mid.valid;
        end
    end

    assign o_item = r_item;
endmodule

// ===== tb/weighted_sum_newton_divide_unit_test.sv =====
module weighted_sum_newton_divide_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wsnd_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_first_operand;
    logic [31:0] i_first_weight;
    logic [31:0] i_second_operand;
    logic [31:0] i_second_weight;
    logic [31:0] i_offset_term;
    logic [31:0] i_divisor;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_quotient;

    logic [31:0] quotient_q[$];
    int          fail_count;
    int          hold_left;
    int          stall_left;
    bit          sink_busy_free;
    bit          source_busy_free;
    int          quiet_cycles;

    weighted_sum_newton_divide_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_first_operand  (i_first_operand),
        .i_first_weight   (i_first_weight),
        .i_second_operand (i_second_operand),
        .i_second_weight  (i_second_weight),
        .i_offset_term    (i_offset_term),
        .i_divisor        (i_divisor),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_quotient       (o_quotient)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ---------------- binary32 arithmetic, round to nearest even ----------------

    function automatic bit is_nan(input logic [31:0] w);
        return (w[30:23] == 8'hff) && (w[22:0] != 23'd0);
    endfunction

    function automatic bit is_inf(input logic [31:0] w);
        return (w[30:23] == 8'hff) && (w[22:0] == 23'd0);
    endfunction

    // value = m * 2**lsb
    function automatic void split_word(input logic [31:0] w, output logic [63:0] m,
                                       output int lsb);
        if (w[30:23] == 8'd0) begin
            m   = {41'd0, w[22:0]};
            lsb = -149;
        end else begin
            m   = {40'd0, 1'b1, w[22:0]};
            lsb = int'(w[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] pack_rne(input logic s, input logic [63:0] m, input int x);
        int          p;
        int          lsb;
        int          sh;
        logic [63:0] keep;
        logic        half;
        logic        sticky;
        if (m == 64'd0) begin
            return {s, 31'd0};
        end
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) begin
                p = i;
            end
        end
        lsb = (p + x - 23 < -149) ? -149 : p + x - 23;
        sh  = lsb - x;
        if (sh <= 0) begin
            keep   = m << (-sh);
            half   = 1'b0;
            sticky = 1'b0;
        end else if (sh > 64) begin
            keep   = 64'd0;
            half   = 1'b0;
            sticky = 1'b1;
        end else begin
            keep   = (sh == 64) ? 64'd0 : (m >> sh);
            half   = m[sh-1];
            sticky = (sh > 1) && ((m & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0);
        end
        if (half && (sticky || keep[0])) begin
            keep = keep + 64'd1;
        end
        if (keep[24]) begin
            keep = keep >> 1;
            lsb  = lsb + 1;
        end
        if (keep[23]) begin
            if (lsb + 150 >= 255) begin
                return {s, 8'hff, 23'd0};
            end
            return {s, 8'(lsb + 150), keep[22:0]};
        end
        return {s, 8'd0, keep[22:0]};
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic [63:0] ma, mb;
        int          la, lb;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b) || (is_inf(a) && b[30:0] == 31'd0) ||
            (is_inf(b) && a[30:0] == 31'd0)) begin
            return QNAN;
        end
        if (is_inf(a) || is_inf(b)) begin
            return {s, 8'hff, 23'd0};
        end
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
            return {s, 31'd0};
        end
        split_word(a, ma, la);
        split_word(b, mb, lb);
        return pack_rne(s, ma * mb, la + lb);
    endfunction

    function automatic logic [31:0] add32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big, tiny;
        logic [63:0] mx, my, r;
        int          lx, ly, d;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31])) begin
            return QNAN;
        end
        if (is_inf(a)) begin
            return a;
        end
        if (is_inf(b)) begin
            return b;
        end
        if (a[30:0] >= b[30:0]) begin
            big  = a;
            tiny = b;
        end else begin
            big  = b;
            tiny = a;
        end
        split_word(big, mx, lx);
        split_word(tiny, my, ly);
        mx = mx << 30;
        d  = lx - ly;
        if (d <= 30) begin
            my = my << (30 - d);
        end else if (d - 30 >= 64) begin
            my = {63'd0, my != 64'd0};
        end else begin
            my = (my >> (d - 30)) | {63'd0, (my & ((64'd1 << (d - 30)) - 64'd1)) != 64'd0};
        end
        r = (big[31] == tiny[31]) ? mx + my : mx - my;
        if (r == 64'd0) begin
            return {a[31] & b[31], 31'd0};
        end
        return pack_rne(big[31], r, lx - 30);
    endfunction

    function automatic logic [31:0] predict_quotient(input logic [31:0] a, input logic [31:0] b,
                                                     input logic [31:0] c, input logic [31:0] d,
                                                     input logic [31:0] e, input logic [31:0] f);
        logic [31:0] num, recip, q, t, k;
        logic [7:0]  fe;
        if (f[30:0] == 31'd0 || f[30:23] == 8'hff) begin
            return BAD_WORD;
        end
        num = add32(add32(mul32(a, b), mul32(c, d)), e);
        fe  = f[30:23];
        // seed exponent out of range gives a signed zero
        if (fe == 8'd0 || fe > 8'd252) begin
            recip = {f[31], 31'd0};
        end else begin
            recip = {f[31], 8'(9'd253 - {1'b0, fe}), SEED_MANT[f[22:16]]};
        end
        q = mul32(num, recip);
        t = mul32(recip, f);
        for (int i = 0; i < NEWTON_ROUNDS; i++) begin
            k = add32(TWO_F, {~t[31], t[30:0]});
            q = mul32(q, k);
            t = mul32(k, t);
        end
        return is_nan(q) ? BAD_WORD : q;
    endfunction

    // ---------------- result side ----------------

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (quotient_q.size() == 0) begin
                    $error("unexpected result quotient %h", o_quotient);
                    fail_count++;
                end else begin
                    if (o_quotient !== quotient_q[0]) begin
                        $error("quotient expected %h actual %h", quotient_q[0], o_quotient);
                        fail_count++;
                    end
                    void'(quotient_q.pop_front());
                end
                stall_left = sink_busy_free ? 0 : $urandom_range(0, 9);
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ---------------- request side ----------------

    task automatic send_request(input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] c, input logic [31:0] d,
                                input logic [31:0] e, input logic [31:0] f);
        int gap;
        gap = source_busy_free ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_first_operand  <= a;
        i_first_weight   <= b;
        i_second_operand <= c;
        i_second_weight  <= d;
        i_offset_term    <= e;
        i_divisor        <= f;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        quotient_q.push_back(predict_quotient(a, b, c, d, e, f));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (quotient_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] specials[8];
        specials = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
                     32'h7fc00001, 32'h00000001, 32'h007fffff, 32'h7f7fffff};
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return specials[$urandom_range(0, 7)];
            default: return {1'($urandom), 8'($urandom_range(105, 150)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] rand_divisor();
        case ($urandom_range(0, 19))
            0: return {1'($urandom), 8'd0, 23'($urandom)};
            1: return {1'($urandom), 8'($urandom_range(252, 255)), 23'($urandom)};
            2: return $urandom;
            default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                source_busy_free = ($urandom_range(0, 3) == 0);
                sink_busy_free   = ($urandom_range(0, 3) == 0);
            end
            send_request(rand_float(), rand_float(), rand_float(), rand_float(),
                         rand_float(), rand_divisor());
        end
        source_busy_free = 1'b0;
        sink_busy_free   = 1'b0;
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        send_request(32'h3f800000, 32'h3f800000, 32'h3f800000, 32'h3f800000,
                     32'h3f800000, 32'h40400000);
        send_request(32'h40000000, 32'h40400000, 32'hbf800000, 32'h40800000,
                     32'h3f000000, 32'h3fffffff);
        // bad divisors
        send_request(32'h3f800000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'h00000000);
        send_request(32'h3f800000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'h80000000);
        send_request(32'h3f800000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'h7f800000);
        send_request(32'h3f800000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'hff800000);
        send_request(32'h3f800000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'h7fc00000);
        send_request(32'h3f800000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'hffffffff);
        // seed exponent out of range, then the in-range edge exponents 252 and 1
        send_request(32'h3f800000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'h00400000);
        send_request(32'h3f800000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'h807fffff);
        send_request(32'h3f800000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'h7e800000);
        send_request(32'h3f800000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'hff7fffff);
        send_request(32'h3f800000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'h7e7fffff);
        send_request(32'h3f800000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'h00800000);
        // nan numerator, inf times zero, overflow, opposite infinities
        send_request(32'h7fc00000, 32'h3f800000, 32'h0, 32'h0, 32'h0, 32'h3f800000);
        send_request(32'h7f800000, 32'h00000000, 32'h0, 32'h0, 32'h0, 32'h3f800000);
        send_request(32'h7f7fffff, 32'h7f7fffff, 32'h0, 32'h0, 32'h0, 32'h3f800000);
        send_request(32'h7f800000, 32'h3f800000, 32'hff800000, 32'h3f800000, 32'h0,
                     32'h40000000);
        // denormal operands, exact cancellation and nan operands
        send_request(32'h00000001, 32'h3f800000, 32'h807fffff, 32'h3f800000,
                     32'h00000001, 32'h3f000000);
        send_request(32'h3f800000, 32'h3f800000, 32'hbf800000, 32'h3f800000,
                     32'h80000000, 32'h3fc00000);
        send_request(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     32'hffffffff, 32'h3f800000);
        send_request(32'h7fffffff, 32'h00000000, 32'h80000000, 32'h00000000,
                     32'h7f7fffff, 32'h00800001);
        wait_drained();
    endtask

    task automatic test_backpressure();
        // sink holds off while requests keep coming, the pipeline fills and stalls
        hold_left        = 200;
        source_busy_free = 1'b1;
        for (int n = 0; n < 40; n++) begin
            send_request(rand_float(), rand_float(), rand_float(), rand_float(),
                         rand_float(), rand_divisor());
        end
        source_busy_free = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        send_random(450);
        wait_drained();
        send_random(450);
    endtask

    initial begin
        fail_count       = 0;
        hold_left        = 0;
        stall_left       = 0;
        quiet_cycles     = 0;
        sink_busy_free   = 1'b0;
        source_busy_free = 1'b0;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_ready          <= 1'b0;
        i_first_operand  <= 32'd0;
        i_first_weight   <= 32'd0;
        i_second_operand <= 32'd0;
        i_second_weight  <= 32'd0;
        i_offset_term    <= 32'd0;
        i_divisor        <= 32'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (30) @(posedge i_clk);

        if (fail_count == 0 && quotient_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wsnd_pkg.sv
rtl/wsnd_front.sv
rtl/wsnd_newton_cell.sv
rtl/weighted_sum_newton_divide_unit.sv
tb/weighted_sum_newton_divide_unit_test.sv
